@@ sv/smseq_pkg.sv @@
package smseq_pkg;

  // Default number of servo outputs.
  localparam int SERVO_COUNT_DEF = 5;

  // Field widths.
  localparam int TimeW  = 32;
  localparam int LevelW = 16;
  localparam int PosW   = 16;
  localparam int DwellW = 31;
  localparam int SelW   = 3;
  localparam int ModeW  = 2;
  localparam int IdxW   = 3;
  localparam int CfgW   = 31;

  // Motion modes.
  localparam logic [ModeW-1:0] MODE_SWEEP_RETURN = 2'd0;
  localparam logic [ModeW-1:0] MODE_SWEEP        = 2'd1;
  localparam logic [ModeW-1:0] MODE_WAG          = 2'd2;
  localparam logic [ModeW-1:0] MODE_GOTO         = 2'd3;

  // Register indexes.
  localparam logic [IdxW-1:0] REG_MODE      = 3'd0;
  localparam logic [IdxW-1:0] REG_THRESHOLD = 3'd1;
  localparam logic [IdxW-1:0] REG_POS_A     = 3'd2;
  localparam logic [IdxW-1:0] REG_POS_B     = 3'd3;
  localparam logic [IdxW-1:0] REG_DWELL_A   = 3'd4;
  localparam logic [IdxW-1:0] REG_DWELL_B   = 3'd5;
  localparam logic [IdxW-1:0] REG_SERVO_SEL = 3'd6;

  // Configuration register set.
  typedef struct packed {
    logic [ModeW-1:0]         mode;
    logic signed [LevelW-1:0] trigger_threshold;
    logic [PosW-1:0]          position_a;
    logic [PosW-1:0]          position_b;
    logic [DwellW-1:0]        dwell_a;
    logic [DwellW-1:0]        dwell_b;
    logic [SelW-1:0]          servo_select;
  } cfg_t;

  // One servo write produced by the motion logic.
  typedef struct packed {
    logic            hit;
    logic [SelW-1:0] servo_index;
    logic [PosW-1:0] position;
  } res_t;

endpackage

@@ sv/servo_motion_sequencer.sv @@
// An accepted input word is held in the input register and its result word in the
// output register. Throughput: one input word per cycle unless the output stalls;
// a tick that moves no servo gives no result. The input register, the motion logic
// and the output register form one pass, so the per-tick state update sets the rate.
// Reset (synchronous, active high) clears the configuration, the motion state
// and both pipeline valid flags.
module servo_motion_sequencer #(
  parameter int SERVO_COUNT = smseq_pkg::SERVO_COUNT_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [47:0]                s_tdata,   // now[31:0], level[47:32]
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [23:0]                m_tdata,   // servo_index[2:0], position[18:3], zeros
  input  logic                       cfg_we,
  input  logic [smseq_pkg::IdxW-1:0] cfg_index,
  input  logic [smseq_pkg::CfgW-1:0] cfg_data
);

  smseq_pkg::cfg_t cfg;
  smseq_pkg::res_t res;

  logic                                in_valid;
  logic [smseq_pkg::TimeW-1:0]         in_now;
  logic signed [smseq_pkg::LevelW-1:0] in_level;
  logic                                advance;
  logic                                out_valid;
  logic [smseq_pkg::SelW-1:0]          out_index;
  logic [smseq_pkg::PosW-1:0]          out_position;

  smseq_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The held word moves on when the output register is free or being emptied.
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_now   <= s_tdata[31:0];
      in_level <= s_tdata[47:32];
    end
  end

  smseq_step #(
    .SERVO_COUNT (SERVO_COUNT)
  ) u_step (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .fire  (advance),
    .now   (in_now),
    .level (in_level),
    .res   (res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res.hit;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_index    <= res.servo_index;
      out_position <= res.position;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'd0, out_position, out_index};

  // A word taken into an empty or moving input register is held next cycle.
  a_in_taken: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> in_valid)
    else $error("accepted input word lost");

  // A held word that cannot move stays held.
  a_in_kept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid)
    else $error("stalled input word dropped");

  // Results only address servos that exist.
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ({29'd0, out_index} < 32'(SERVO_COUNT)))
    else $error("result addresses a missing servo");

  // Reset empties the output register.
  a_reset_clear: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid after reset");

endmodule

@@ sv/smseq_cfg.sv @@
module smseq_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [smseq_pkg::IdxW-1:0]   cfg_index,
  input  logic [smseq_pkg::CfgW-1:0]   cfg_data,
  output smseq_pkg::cfg_t              cfg
);

  // Register file, written one register at a time.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        smseq_pkg::REG_MODE:      cfg.mode <= cfg_data[smseq_pkg::ModeW-1:0];
        smseq_pkg::REG_THRESHOLD: cfg.trigger_threshold <= cfg_data[smseq_pkg::LevelW-1:0];
        smseq_pkg::REG_POS_A:     cfg.position_a <= cfg_data[smseq_pkg::PosW-1:0];
        smseq_pkg::REG_POS_B:     cfg.position_b <= cfg_data[smseq_pkg::PosW-1:0];
        smseq_pkg::REG_DWELL_A:   cfg.dwell_a <= cfg_data[smseq_pkg::DwellW-1:0];
        smseq_pkg::REG_DWELL_B:   cfg.dwell_b <= cfg_data[smseq_pkg::DwellW-1:0];
        smseq_pkg::REG_SERVO_SEL: cfg.servo_select <= cfg_data[smseq_pkg::SelW-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

@@ sv/smseq_step.sv @@
module smseq_step #(
  parameter int SERVO_COUNT = smseq_pkg::SERVO_COUNT_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  smseq_pkg::cfg_t                    cfg,
  input  logic                               fire,
  input  logic [smseq_pkg::TimeW-1:0]        now,
  input  logic signed [smseq_pkg::LevelW-1:0] level,
  output smseq_pkg::res_t                    res
);

  logic                        pending;
  logic                        active;
  logic [smseq_pkg::TimeW-1:0] start_time;
  logic [smseq_pkg::PosW-1:0]  current_position;

  logic                        pending_next;
  logic                        active_next;
  logic [smseq_pkg::TimeW-1:0] start_time_next;
  logic [smseq_pkg::PosW-1:0]  current_position_next;

  logic [smseq_pkg::TimeW-1:0] elapsed;
  logic [smseq_pkg::TimeW-1:0] dwell_sum;
  logic                        e_lt_a;
  logic                        e_lt_b;
  logic                        e_gt_sum;
  logic                        level_above;
  logic                        level_below;
  logic                        at_a;
  logic                        at_b;
  logic                        hit;
  logic [smseq_pkg::PosW-1:0]  pos;
  logic                        in_range;

  // Wrapping elapsed time and the dwell compares.
  assign elapsed     = now - start_time;
  assign dwell_sum   = {1'b0, cfg.dwell_a} + {1'b0, cfg.dwell_b};
  assign e_lt_a      = elapsed < {1'b0, cfg.dwell_a};
  assign e_lt_b      = elapsed < {1'b0, cfg.dwell_b};
  assign e_gt_sum    = elapsed > dwell_sum;
  assign level_above = cfg.trigger_threshold < level;
  assign level_below = level < cfg.trigger_threshold;
  assign at_a        = current_position == cfg.position_a;
  assign at_b        = current_position == cfg.position_b;

  // Per-tick motion decision.
  always_comb begin
    pending_next          = pending;
    active_next           = active;
    start_time_next       = start_time;
    current_position_next = current_position;
    hit                   = 1'b0;
    pos                   = cfg.position_a;
    unique case (cfg.mode)
      smseq_pkg::MODE_SWEEP_RETURN: begin
        if (pending) begin
          if (!e_lt_a) begin
            hit = 1'b1;
            if (e_gt_sum) begin
              pending_next = 1'b0;
            end else begin
              pos = cfg.position_b;
            end
          end
        end else if (level_above) begin
          pending_next    = 1'b1;
          active_next     = 1'b0;
          start_time_next = now;
        end
      end
      smseq_pkg::MODE_SWEEP: begin
        if (pending) begin
          if (at_a) begin
            if (!e_lt_a) begin
              hit                   = 1'b1;
              pos                   = cfg.position_b;
              current_position_next = cfg.position_b;
              pending_next          = 1'b0;
            end
          end else if (!e_lt_b) begin
            hit                   = 1'b1;
            current_position_next = cfg.position_a;
            pending_next          = 1'b0;
          end
        end else if (level_above) begin
          pending_next    = 1'b1;
          active_next     = 1'b0;
          start_time_next = now;
          if (!at_a && !at_b) begin
            hit                   = 1'b1;
            current_position_next = cfg.position_a;
          end
        end
      end
      smseq_pkg::MODE_WAG: begin
        if (active) begin
          if (level_below) begin
            active_next = 1'b0;
          end else if (at_a) begin
            if (!e_lt_a) begin
              hit                   = 1'b1;
              pos                   = cfg.position_b;
              start_time_next       = now;
              current_position_next = cfg.position_b;
            end
          end else if (!e_lt_b) begin
            hit                   = 1'b1;
            start_time_next       = now;
            current_position_next = cfg.position_a;
          end
        end else if (level_above) begin
          active_next     = 1'b1;
          start_time_next = now;
        end
      end
      smseq_pkg::MODE_GOTO: begin
        if (pending) begin
          if (!e_lt_a) begin
            hit          = 1'b1;
            pending_next = 1'b0;
          end
        end else if (level_above) begin
          pending_next    = 1'b1;
          start_time_next = now;
        end
      end
      default: begin
      end
    endcase
  end

  // A write to a servo that does not exist goes nowhere.
  assign in_range = {29'd0, cfg.servo_select} < 32'(SERVO_COUNT);

  assign res.hit         = hit && in_range;
  assign res.servo_index = cfg.servo_select;
  assign res.position    = pos;

  // Motion state, updated once per word.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending          <= 1'b0;
      active           <= 1'b0;
      start_time       <= '0;
      current_position <= '0;
    end else if (fire) begin
      pending          <= pending_next;
      active           <= active_next;
      start_time       <= start_time_next;
      current_position <= current_position_next;
    end
  end

endmodule
